@@ rtl/swarq_pkg.sv @@
// ----------------------------------------------------------------------------
// swarq_pkg: shared types and constants of the stop-and-wait ARQ sender
// Command codes, configuration register indexes, fixed field widths and the
// default values of the top-level parameters.
// ----------------------------------------------------------------------------
package swarq_pkg;

  // Default sizes of the timer and of the sequence number
  localparam int unsigned TIMER_BITS_DEF = 32;
  localparam int unsigned SEQ_BITS_DEF   = 16;

  // Fixed widths of registers and counters
  localparam int unsigned BASE_W  = 16;
  localparam int unsigned LIMIT_W = 8;
  localparam int unsigned ATT_W   = 8;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 16;

  // Event carried by one input beat
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_RESP  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_RETX_EN  = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_BACKOFF  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_SEQ_EN   = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_BASE_TMO = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_RETRY    = 3'd4;

endpackage

@@ rtl/stop_wait_arq_sender.sv @@
// ----------------------------------------------------------------------------
// stop_wait_arq_sender: sender side of a stop-and-wait ARQ exchange
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one event per beat: a
//   start, a timer tick, a received response or a clear of the statistics.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result
//   beat per input beat, in order: transmit request, packet sequence number,
//   finished / delivered flags, retransmission total and busy status.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
//   no beat is in flight; writes to unused indexes are dropped.
// Pipeline and throughput:
//   A beat passes through the input register, then the output register,
//   where its result shows. One beat per cycle is sustained while the
//   receiver does not stall; the critical path is the timeout barrel shifter
//   with its saturation check, followed by the retry-limit compare.
// Reset:
//   All configuration and exchange state clear to zero; both pipeline
//   registers are empty. No clearing pass is needed.
// Stall:
//   A stalled result holds in the output register; the input register still
//   takes one more beat, after which in_stall_o rises until the result moves.
// ----------------------------------------------------------------------------
module stop_wait_arq_sender #(
  parameter int unsigned TIMER_BITS = swarq_pkg::TIMER_BITS_DEF,
  parameter int unsigned SEQ_BITS   = swarq_pkg::SEQ_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [swarq_pkg::CFG_AW-1:0]   cfg_idx_i,
  input  logic [swarq_pkg::CFG_DW-1:0]   cfg_data_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  swarq_pkg::cmd_e                cmd_i,
  input  logic signed [SEQ_BITS-1:0]     start_seq_i,
  input  logic                           resp_is_ack_i,
  input  logic signed [SEQ_BITS-1:0]     resp_seq_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           transmit_o,
  output logic signed [SEQ_BITS-1:0]     packet_seq_o,
  output logic                           finished_o,
  output logic                           delivered_o,
  output logic [swarq_pkg::SUM_W-1:0]    retransmit_total_o,
  output logic                           busy_res_o
);
  import swarq_pkg::*;

  localparam int unsigned SH_W = $clog2(TIMER_BITS);
  localparam int unsigned WIDE = TIMER_BITS + BASE_W;
  localparam logic [SEQ_BITS-1:0] MARKER_NOSEQ = {{(SEQ_BITS-1){1'b1}}, 1'b0};

  // Configuration registers
  logic               retx_en_q, backoff_q, seq_en_q;
  logic [BASE_W-1:0]  base_q;
  logic [LIMIT_W-1:0] limit_q;

  // Input register
  logic                in_valid_q;
  cmd_e                cmd_q;
  logic [SEQ_BITS-1:0] start_seq_q, resp_seq_q;
  logic                is_ack_q;

  // Exchange state
  logic                  waiting_q, waiting_d;
  logic [ATT_W-1:0]      att_q, att_d;
  logic [TIMER_BITS-1:0] time_q, time_d;
  logic [SEQ_BITS-1:0]   seq_q, seq_d;
  logic [SUM_W-1:0]      sum_q, sum_d;

  // Output register
  logic                out_valid_q;
  logic                tx_q, fin_q, dlv_q;
  logic                tx_d, fin_d, dlv_d;

  logic                advance;
  logic                retry;
  logic [SUM_W:0]      sum_ext;
  logic [TIMER_BITS-1:0] time_dec;

  // Timeout of one attempt: base shifted by the attempt when backoff is on, saturating
  function automatic logic [TIMER_BITS-1:0] timeout_f(input logic [ATT_W-1:0] att);
    logic [ATT_W-1:0] amt;
    logic [WIDE-1:0]  wide;
    amt  = backoff_q ? att : '0;
    wide = {{TIMER_BITS{1'b0}}, base_q} << amt[SH_W-1:0];
    if (base_q == '0) begin
      return '0;
    end else if (amt >= ATT_W'(TIMER_BITS)) begin
      return '1;
    end else if (|wide[WIDE-1:TIMER_BITS]) begin
      return '1;
    end else begin
      return wide[TIMER_BITS-1:0];
    end
  endfunction

  // Move a beat from the input register when the output register frees up
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retx_en_q <= 1'b0;
      backoff_q <= 1'b0;
      seq_en_q  <= 1'b0;
      base_q    <= '0;
      limit_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RETX_EN:  retx_en_q <= cfg_data_i[0];
        CFG_BACKOFF:  backoff_q <= cfg_data_i[0];
        CFG_SEQ_EN:   seq_en_q  <= cfg_data_i[0];
        CFG_BASE_TMO: base_q    <= cfg_data_i[BASE_W-1:0];
        CFG_RETRY:    limit_q   <= cfg_data_i[LIMIT_W-1:0];
        default:      ;
      endcase
    end
  end

  // Capture input beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      cmd_q       <= cmd_i;
      start_seq_q <= start_seq_i;
      resp_seq_q  <= resp_seq_i;
      is_ack_q    <= resp_is_ack_i;
    end
  end

  assign time_dec = time_q - 1'b1;
  assign sum_ext  = {1'b0, sum_q} + (SUM_W+1)'(att_q);

  // Process one event against the exchange state
  always_comb begin
    waiting_d = waiting_q;
    att_d     = att_q;
    time_d    = time_q;
    seq_d     = seq_q;
    sum_d     = sum_q;
    tx_d      = 1'b0;
    fin_d     = 1'b0;
    dlv_d     = 1'b0;
    retry     = 1'b0;

    unique case (cmd_q)
      CMD_START: begin
        if (!waiting_q) begin
          seq_d     = seq_en_q ? start_seq_q : MARKER_NOSEQ;
          att_d     = '0;
          waiting_d = 1'b1;
          time_d    = timeout_f('0);
          tx_d      = 1'b1;
        end
      end
      CMD_TICK: begin
        if (waiting_q && (time_q != '0)) begin
          time_d = time_dec;
          if (time_dec == '0) begin
            if (!retx_en_q) begin
              waiting_d = 1'b0;
              fin_d     = 1'b1;
            end else begin
              if (att_q != '1) att_d = att_q + 1'b1;
              retry = 1'b1;
            end
          end
        end
      end
      CMD_RESP: begin
        if (waiting_q) begin
          if (is_ack_q && (resp_seq_q == seq_q)) begin
            sum_d     = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
            waiting_d = 1'b0;
            fin_d     = 1'b1;
            dlv_d     = 1'b1;
          end else begin
            retry = 1'b1;
          end
        end
      end
      CMD_CLEAR: sum_d = '0;
      default: ;
    endcase

    // Resend while attempts remain, else give up
    if (retry) begin
      if (att_d < limit_q) begin
        time_d = timeout_f(att_d);
        tx_d   = 1'b1;
      end else begin
        waiting_d = 1'b0;
        fin_d     = 1'b1;
      end
    end
  end

  // Advance exchange state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q <= 1'b0;
      att_q     <= '0;
      time_q    <= '0;
      seq_q     <= '0;
      sum_q     <= '0;
    end else if (advance) begin
      waiting_q <= waiting_d;
      att_q     <= att_d;
      time_q    <= time_d;
      seq_q     <= seq_d;
      sum_q     <= sum_d;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      tx_q  <= tx_d;
      fin_q <= fin_d;
      dlv_q <= dlv_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign transmit_o         = tx_q;
  assign packet_seq_o       = seq_q;
  assign finished_o         = fin_q;
  assign delivered_o        = dlv_q;
  assign retransmit_total_o = sum_q;
  assign busy_res_o         = waiting_q;

  // Checks
  a_fin_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(fin_q && waiting_q))
    else $error("finished result still shows busy");

  a_dlv_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && dlv_q) |-> fin_q)
    else $error("delivered without finished");

  a_tx_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && tx_q) |-> waiting_q)
    else $error("transmit request while not waiting");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> in_valid_q)
    else $error("input beat lost while stalled");

  a_idle_no_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !waiting_q) |-> !fin_d)
    else $error("exchange ended while idle");

endmodule

@@ tb/sv/stop_wait_arq_sender_tb.sv @@
// ----------------------------------------------------------------------------
// stop_wait_arq_sender_tb: self-checking bench for the stop-and-wait sender
// Drives start, tick, response and clear beats through the valid/stall input
// channel. A shadow of the sender state predicts one result beat per input
// beat, and each result beat is compared field by field, in order. Runs a
// directed sweep, then random bursts under several register settings, most
// with idle gaps on both channels, and two long receiver hold-offs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stop_wait_arq_sender_tb;
  import swarq_pkg::*;

  localparam int unsigned SEQ_W        = SEQ_BITS_DEF;
  localparam int unsigned TMR_W        = TIMER_BITS_DEF;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned BURST_BEATS  = 150;
  localparam logic [SEQ_W-1:0] NOSEQ_MARK = ~{{(SEQ_W-1){1'b0}}, 1'b1};
  localparam logic [SEQ_W-1:0] LAST_SEQ   = '1;
  localparam logic [SEQ_W-1:0] TOP_SEQ    = {1'b0, {(SEQ_W-1){1'b1}}};

  // One result beat as the sender reports it
  typedef struct packed {
    logic             transmit;
    logic [SEQ_W-1:0] packet_seq;
    logic             finished;
    logic             delivered;
    logic [SUM_W-1:0] total;
    logic             busy;
  } arq_result_t;

  // Shadow of the sender: registers, exchange state and the results still due
  class arq_tracker;
    logic               retx_en    = 1'b0;
    logic               backoff_en = 1'b0;
    logic               seq_en     = 1'b0;
    logic [BASE_W-1:0]  base_tmo   = '0;
    logic [LIMIT_W-1:0] retry_max  = '0;
    logic               waiting    = 1'b0;
    logic [ATT_W-1:0]   attempts   = '0;
    logic [TMR_W-1:0]   time_left  = '0;
    logic [SEQ_W-1:0]   cur_seq    = '0;
    logic [SUM_W-1:0]   sum        = '0;
    arq_result_t        due_results[$];
    int unsigned        faults     = 0;

    function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        CFG_RETX_EN:  retx_en    = data[0];
        CFG_BACKOFF:  backoff_en = data[0];
        CFG_SEQ_EN:   seq_en     = data[0];
        CFG_BASE_TMO: base_tmo   = data[BASE_W-1:0];
        CFG_RETRY:    retry_max  = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    // Timeout of the current attempt, saturating at all ones of the timer
    function logic [TMR_W-1:0] timeout_len();
      logic [ATT_W-1:0] sh;
      logic [63:0]      wide;
      sh = backoff_en ? attempts : '0;
      if (base_tmo == 0) return '0;
      if (sh >= TMR_W) return '1;
      wide = 64'(base_tmo) << sh;
      if ((wide >> TMR_W) != 0) return '1;
      return wide[TMR_W-1:0];
    endfunction

    // Advance the shadow by one accepted beat and queue its result
    function void take_event(cmd_e cmd, logic [SEQ_W-1:0] sseq, logic ack,
                             logic [SEQ_W-1:0] rseq);
      arq_result_t    r;
      logic           retry;
      logic [SUM_W:0] acc;
      r     = '0;
      retry = 1'b0;
      case (cmd)
        CMD_START: begin
          if (!waiting) begin
            cur_seq   = seq_en ? sseq : NOSEQ_MARK;
            attempts  = '0;
            waiting   = 1'b1;
            time_left = timeout_len();
            r.transmit = 1'b1;
          end
        end
        CMD_TICK: begin
          if (waiting && time_left != 0) begin
            time_left = time_left - 1'b1;
            if (time_left == 0) begin
              if (!retx_en) begin
                waiting    = 1'b0;
                r.finished = 1'b1;
              end else begin
                if (attempts != '1) attempts = attempts + 1'b1;
                retry = 1'b1;
              end
            end
          end
        end
        CMD_RESP: begin
          if (waiting) begin
            if (ack && rseq == cur_seq) begin
              acc         = {1'b0, sum} + attempts;
              sum         = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
              waiting     = 1'b0;
              r.finished  = 1'b1;
              r.delivered = 1'b1;
            end else begin
              retry = 1'b1;
            end
          end
        end
        default: sum = '0;
      endcase
      // Resend while attempts remain, otherwise give up
      if (retry) begin
        if (attempts < retry_max) begin
          time_left  = timeout_len();
          r.transmit = 1'b1;
        end else begin
          waiting    = 1'b0;
          r.finished = 1'b1;
        end
      end
      r.packet_seq = cur_seq;
      r.total      = sum;
      r.busy       = waiting;
      due_results.push_back(r);
    endfunction

    // Compare one result beat against the oldest one due
    function void match_result(arq_result_t got);
      arq_result_t want;
      if (due_results.size() == 0) begin
        faults++;
        if (faults <= MAX_REPORTS)
          $display("%0t: result beat with nothing due: tx=%0b seq=%h fin=%0b dlv=%0b",
                   $time, got.transmit, got.packet_seq, got.finished, got.delivered);
        return;
      end
      want = due_results.pop_front();
      if (got.transmit !== want.transmit || got.packet_seq !== want.packet_seq ||
          got.finished !== want.finished || got.delivered !== want.delivered ||
          got.total !== want.total || got.busy !== want.busy) begin
        faults++;
        if (faults <= MAX_REPORTS) begin
          $display("%0t: mismatch: expected tx=%0b seq=%h fin=%0b dlv=%0b total=%0d busy=%0b",
                   $time, want.transmit, want.packet_seq, want.finished, want.delivered,
                   want.total, want.busy);
          $display("%0t: mismatch: actual   tx=%0b seq=%h fin=%0b dlv=%0b total=%0d busy=%0b",
                   $time, got.transmit, got.packet_seq, got.finished, got.delivered,
                   got.total, got.busy);
        end
      end
    endfunction
  endclass

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_we_i      = 1'b0;
  logic [CFG_AW-1:0]       cfg_idx_i     = '0;
  logic [CFG_DW-1:0]       cfg_data_i    = '0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_stall_o;
  cmd_e                    cmd_i         = CMD_TICK;
  logic signed [SEQ_W-1:0] start_seq_i   = '0;
  logic                    resp_is_ack_i = 1'b0;
  logic signed [SEQ_W-1:0] resp_seq_i    = '0;
  logic                    out_valid_o;
  logic                    out_stall_i   = 1'b0;
  logic                    transmit_o;
  logic signed [SEQ_W-1:0] packet_seq_o;
  logic                    finished_o;
  logic                    delivered_o;
  logic [SUM_W-1:0]        retransmit_total_o;
  logic                    busy_res_o;

  arq_tracker  tracker     = new();
  int unsigned tx_idle_pct = 37;
  int unsigned rx_idle_pct = 45;
  int unsigned hold_req    = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;
  int unsigned cycle_count = 0;

  stop_wait_arq_sender #(
    .TIMER_BITS (TMR_W),
    .SEQ_BITS   (SEQ_W)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .cmd_i              (cmd_i),
    .start_seq_i        (start_seq_i),
    .resp_is_ack_i      (resp_is_ack_i),
    .resp_seq_i         (resp_seq_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .transmit_o         (transmit_o),
    .packet_seq_o       (packet_seq_o),
    .finished_o         (finished_o),
    .delivered_o        (delivered_o),
    .retransmit_total_o (retransmit_total_o),
    .busy_res_o         (busy_res_o)
  );

  always #1 clk_i = ~clk_i;

  // Receiver: check each result beat, then stall at random or hold off
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.match_result({transmit_o, packet_seq_o, finished_o, delivered_o,
                            retransmit_total_o, busy_res_o});
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left   = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("stop_wait_arq_sender_tb: done, errors");
      $finish;
    end
  end

  // Offer one beat after a random gap, hold it until taken, then predict
  task automatic send_event(cmd_e cmd, logic [SEQ_W-1:0] sseq, logic ack,
                            logic [SEQ_W-1:0] rseq);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    start_seq_i   <= sseq;
    resp_is_ack_i <= ack;
    resp_seq_i    <= rseq;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.take_event(cmd, sseq, ack, rseq);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.set_reg(idx, data);
  endtask

  task automatic load_config(logic retx, logic backoff, logic seq_on,
                             logic [BASE_W-1:0] base, logic [LIMIT_W-1:0] limit);
    write_reg(CFG_RETX_EN, CFG_DW'(retx));
    write_reg(CFG_BACKOFF, CFG_DW'(backoff));
    write_reg(CFG_SEQ_EN, CFG_DW'(seq_on));
    write_reg(CFG_BASE_TMO, CFG_DW'(base));
    write_reg(CFG_RETRY, CFG_DW'(limit));
    cfg_we_i <= 1'b0;
  endtask

  // Drop valid and wait until every result is in, plus a margin
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mostly well-formed exchanges with random content, some noise
  task automatic random_burst(int unsigned count);
    cmd_e             cmd;
    logic [SEQ_W-1:0] sseq;
    logic [SEQ_W-1:0] rseq;
    logic             ack;
    int unsigned      roll;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      sseq = ($urandom_range(15) == 0) ? LAST_SEQ : SEQ_W'($urandom_range(32767));
      rseq = SEQ_W'($urandom());
      ack  = 1'($urandom_range(1));
      if (!tracker.waiting) begin
        if (roll < 80)      cmd = CMD_START;
        else if (roll < 88) cmd = CMD_TICK;
        else if (roll < 95) cmd = CMD_RESP;
        else                cmd = CMD_CLEAR;
      end else begin
        if (roll < 50) begin
          cmd = CMD_TICK;
        end else if (roll < 88) begin
          cmd = CMD_RESP;
          if ($urandom_range(99) < 55) begin
            ack  = 1'b1;
            rseq = tracker.cur_seq;
          end
        end else if (roll < 94) begin
          cmd = CMD_START;
        end else begin
          cmd = CMD_CLEAR;
        end
      end
      send_event(cmd, sseq, ack, rseq);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: no sequencing, no timeout, no retries
    send_event(CMD_TICK, '0, 1'b1, '0);
    send_event(CMD_RESP, '0, 1'b1, NOSEQ_MARK);
    send_event(CMD_CLEAR, '0, 1'b0, '0);
    send_event(CMD_START, TOP_SEQ, 1'b0, '0);
    send_event(CMD_START, '0, 1'b0, '0);
    send_event(CMD_TICK, '0, 1'b0, '0);
    send_event(CMD_RESP, '0, 1'b0, NOSEQ_MARK);
    send_event(CMD_START, LAST_SEQ, 1'b0, '0);
    send_event(CMD_RESP, '0, 1'b1, NOSEQ_MARK);
    settle();

    // Resend on wrong ACK, NACK and timeout; give up at the retry limit
    load_config(1'b1, 1'b0, 1'b1, 16'd2, 8'd3);
    send_event(CMD_START, TOP_SEQ, 1'b0, '0);
    send_event(CMD_RESP, '0, 1'b1, '0);
    send_event(CMD_RESP, '0, 1'b0, TOP_SEQ);
    send_event(CMD_TICK, '0, 1'b0, '0);
    send_event(CMD_TICK, '0, 1'b0, '0);
    send_event(CMD_RESP, '0, 1'b1, TOP_SEQ);
    send_event(CMD_START, LAST_SEQ, 1'b0, '0);
    repeat (6) send_event(CMD_TICK, '0, 1'b0, '0);
    send_event(CMD_START, '0, 1'b0, '0);
    send_event(CMD_RESP, '0, 1'b1, LAST_SEQ);
    send_event(CMD_RESP, '0, 1'b1, '0);
    send_event(CMD_CLEAR, '0, 1'b1, '0);
    settle();

    // Backoff doubles the wait per attempt
    load_config(1'b1, 1'b1, 1'b1, 16'd1, 8'd4);
    send_event(CMD_START, 16'd5, 1'b0, '0);
    repeat (3) send_event(CMD_TICK, '0, 1'b0, '0);
    send_event(CMD_RESP, '0, 1'b1, 16'd5);
    settle();

    // Retransmission off: the first timeout ends the exchange
    load_config(1'b0, 1'b0, 1'b1, 16'd1, 8'd5);
    send_event(CMD_START, 16'd9, 1'b0, '0);
    send_event(CMD_TICK, '0, 1'b0, '0);
    settle();

    // Run the attempt count up to its top
    load_config(1'b1, 1'b0, 1'b0, 16'd1, 8'd255);
    send_event(CMD_START, 16'd7, 1'b0, '0);
    repeat (254) send_event(CMD_TICK, '0, 1'b0, '0);
    send_event(CMD_RESP, '0, 1'b1, NOSEQ_MARK);
    send_event(CMD_START, 16'd7, 1'b0, '0);
    repeat (255) send_event(CMD_TICK, '0, 1'b0, '0);
    settle();

    // Random bursts over several settings and idling modes
    for (int unsigned burst = 0; burst < 6; burst++) begin
      case (burst)
        0: load_config(1'b1, 1'b0, 1'b1, 16'd2, 8'd3);
        1: load_config(1'b1, 1'b1, 1'b1, 16'd1, 8'd255);
        2: load_config(1'b0, 1'b0, 1'b0, 16'd3, 8'd2);
        3: load_config(1'b1, 1'b1, 1'b0, 16'hFFFF, 8'd0);
        4: load_config(1'b1, 1'b0, 1'b1, 16'd0, 8'd1);
        default: load_config(1'($urandom_range(1)), 1'($urandom_range(1)),
                             1'($urandom_range(1)),
                             BASE_W'($urandom_range(1, 4)),
                             LIMIT_W'($urandom_range(0, 4)));
      endcase
      if (burst < 2) begin
        tx_idle_pct = 37;
        rx_idle_pct = 45;
      end else if (burst < 4) begin
        tx_idle_pct = 45;
        rx_idle_pct = 37;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // Hold off the receiver so the block fills and stalls its input
      if (burst == 0 || burst == 2) hold_req = hold_req + 1;
      random_burst(BURST_BEATS);
      settle();
    end

    if (tracker.faults == 0 && tracker.due_results.size() == 0) begin
      $display("stop_wait_arq_sender_tb: done, clean");
    end else begin
      $display("stop_wait_arq_sender_tb: done, errors");
    end
    $finish;
  end

endmodule
